### hw/rtl/two_ring_multicast_next_hop_core_macros.svh
// assertion macros for the two-ring multicast next-hop core
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef TWO_RING_MULTICAST_NEXT_HOP_CORE_MACROS_SVH
`define TWO_RING_MULTICAST_NEXT_HOP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TRMNH_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("trmnh assertion failed");
`define TRMNH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trmnh assertion failed");
`else
`define TRMNH_ASSERT_NOW(label, clk, rst_n, cond)
`define TRMNH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/trmnh_pkg.sv
// shared types and constants of the two-ring multicast next-hop core
// no dependencies
package trmnh_pkg;

    localparam int NODE_W      = 16;
    localparam int SMALL_LIST  = 4;
    localparam int SMALL_IDX_W = $clog2(SMALL_LIST);

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NONE = 2'd1,
        STAT_ERR  = 2'd2
    } trmnh_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SM_DATA,
        ST_SM_FLUSH,
        ST_BIG_NX,
        ST_BIG_MID,
        ST_FWD_DATA,
        ST_SINGLE
    } trmnh_state_t;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        trmnh_status_t     status;
        logic              last;
    } trmnh_result_t;

endpackage

### hw/rtl/trmnh_member_mem.sv
// member list memory: one write port, one read port with registered data
// depends on trmnh_pkg
module trmnh_member_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [trmnh_pkg::NODE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [trmnh_pkg::NODE_W-1:0] rd_data
);
    import trmnh_pkg::*;

    logic [NODE_W-1:0] mem [DEPTH];
    logic [NODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/trmnh_seq.sv
// next-hop sequencer: plans ring positions, reads the member memory, emits results
// depends on trmnh_pkg
module trmnh_seq #(
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         start_role,
    input  logic [CW-1:0]                start_count,
    input  logic                         start_own_found,
    input  logic [AW-1:0]                start_own_pos,
    input  logic                         start_src_found,
    input  logic [AW-1:0]                start_src_pos,
    input  logic [trmnh_pkg::NODE_W-1:0] own_node,
    output logic                         busy,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [trmnh_pkg::NODE_W-1:0] rd_data,
    output logic                         res_valid,
    output trmnh_pkg::trmnh_result_t     res,
    input  logic                         res_ready
);
    import trmnh_pkg::*;

    trmnh_state_t state_reg, state_next;
    logic          role_reg, role_next;
    logic [CW-1:0] n_reg, n_next;
    logic          own_found_reg, own_found_next;
    logic [AW-1:0] own_pos_reg, own_pos_next;
    logic          src_found_reg, src_found_next;
    logic [AW-1:0] src_pos_reg, src_pos_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [SMALL_IDX_W-1:0] idx_reg, idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0] pend_reg, pend_next;
    trmnh_status_t stat_reg, stat_next;

    logic [CW-1:0] half, own_ext, src_ext, own_inc, nx, own_sub, mid, nx_s;
    logic [CW-1:0] start0, start_sub, ring_start;
    logic          own_lo, start_lo, small_list, rd_match;
    logic [SMALL_IDX_W-1:0] idx_inc;

    // ring arithmetic for the current list
    always_comb begin
        half    = n_reg >> 1;
        own_ext = CW'(own_pos_reg);
        src_ext = CW'(src_pos_reg);
        own_lo  = own_ext < half;
        own_inc = own_ext + CW'(1);
        if (own_lo) begin
            nx = (own_inc >= half) ? '0 : own_inc;
        end else begin
            nx = (own_inc >= n_reg) ? half : own_inc;
        end
        own_sub = own_ext - half;
        if (!own_found_reg) begin
            nx_s = '0;
            mid  = half;
        end else begin
            nx_s = nx;
            if (own_lo) begin
                mid = own_ext + half;
            end else begin
                mid = (own_sub >= half) ? '0 : own_sub;
            end
        end
        start0    = src_found_reg ? src_ext : '0;
        start_lo  = start0 < half;
        start_sub = start0 - half;
        if (start_lo != own_lo) begin
            if (start_lo) begin
                ring_start = start0 + half;
            end else begin
                ring_start = (start_sub >= half) ? '0 : start_sub;
            end
        end else begin
            ring_start = start0;
        end
        small_list = n_reg < CW'(SMALL_LIST);
        rd_match   = rd_data == own_node;
        idx_inc    = idx_reg + SMALL_IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        role_reg       <= role_next;
        n_reg          <= n_next;
        own_found_reg  <= own_found_next;
        own_pos_reg    <= own_pos_next;
        src_found_reg  <= src_found_next;
        src_pos_reg    <= src_pos_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        pend_valid_reg <= pend_valid_next;
        pend_reg       <= pend_next;
        stat_reg       <= stat_next;
    end

    always_comb begin
        state_next      = state_reg;
        role_next       = role_reg;
        n_next          = n_reg;
        own_found_next  = own_found_reg;
        own_pos_next    = own_pos_reg;
        src_found_next  = src_found_reg;
        src_pos_next    = src_pos_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        stat_next       = stat_reg;
        busy            = 1'b1;
        rd_en           = 1'b0;
        rd_addr         = '0;
        res_valid       = 1'b0;
        res.dest        = rd_data;
        res.status      = STAT_OK;
        res.last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    role_next      = start_role;
                    n_next         = start_count;
                    own_found_next = start_own_found;
                    own_pos_next   = start_own_pos;
                    src_found_next = start_src_found;
                    src_pos_next   = start_src_pos;
                    state_next     = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (!role_reg) begin
                    if (small_list) begin
                        rd_en           = 1'b1;
                        rd_addr         = '0;
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SM_DATA;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = nx_s[AW-1:0];
                        mid_next   = mid;
                        state_next = ST_BIG_NX;
                    end
                end else begin
                    if (small_list) begin
                        stat_next  = STAT_NONE;
                        state_next = ST_SINGLE;
                    end else if (!own_found_reg) begin
                        stat_next  = STAT_ERR;
                        state_next = ST_SINGLE;
                    end else if (nx == ring_start) begin
                        stat_next  = STAT_NONE;
                        state_next = ST_SINGLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = nx[AW-1:0];
                        state_next = ST_FWD_DATA;
                    end
                end
            end
            ST_SM_DATA: begin
                res.dest = pend_reg;
                res.last = 1'b0;
                if (rd_match || !pend_valid_reg || res_ready) begin
                    if (!rd_match) begin
                        res_valid       = pend_valid_reg;
                        pend_next       = rd_data;
                        pend_valid_next = 1'b1;
                    end
                    idx_next = idx_inc;
                    if (CW'(idx_inc) < n_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_inc);
                    end else begin
                        state_next = ST_SM_FLUSH;
                    end
                end
            end
            ST_SM_FLUSH: begin
                res.dest   = pend_valid_reg ? pend_reg : '0;
                res.status = pend_valid_reg ? STAT_OK : STAT_NONE;
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BIG_NX: begin
                res.last = 1'b0;
                if (rd_match) begin
                    stat_next  = STAT_ERR;
                    state_next = ST_SINGLE;
                end else if (res_ready) begin
                    res_valid  = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = mid_reg[AW-1:0];
                    state_next = ST_BIG_MID;
                end
            end
            ST_BIG_MID, ST_FWD_DATA: begin
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE: begin
                res.dest   = '0;
                res.status = stat_reg;
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/two_ring_multicast_next_hop_core.sv
// top level of the two-ring multicast next-hop core: list loading, output register
// depends on trmnh_pkg, trmnh_member_mem, trmnh_seq and the macros header
// Member list entries are taken one per cycle while the block is idle; each is written
// to the member memory and compared with the own and source node ids. The entry with
// tlast set ends the list: the block then stops taking items until the sequencer
// is idle again; the sequencer reads the member memory, one read per cycle on its
// single read port while m_tready does not hold a result back, and emits one to
// three results. The last result of a list carries m_tlast. A result waiting in the
// output register does not block new list entries.
`include "two_ring_multicast_next_hop_core_macros.svh"

module two_ring_multicast_next_hop_core #(
    parameter int MAX_MEMBERS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // own_node
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // entry_node[15:0], source_node[31:16]
    input  logic        s_tlast,       // is_last
    input  logic        s_tuser,       // role
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // dest_node[15:0]
    output logic [1:0]  m_tuser,       // status[1:0]
    output logic        m_tlast        // last_dest
);
    import trmnh_pkg::*;

    localparam int AW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);

    logic [NODE_W-1:0] own_node_reg, own_node_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              own_found_reg, own_found_next;
    logic [AW-1:0]     own_pos_reg, own_pos_next;
    logic              src_found_reg, src_found_next;
    logic [AW-1:0]     src_pos_reg, src_pos_next;
    logic              m_tvalid_reg, m_tvalid_next;
    trmnh_result_t     m_res_reg, m_res_next;

    logic [NODE_W-1:0] entry_node, source_node, rd_data;
    logic              accept, wr_ok, hit_own, hit_src, busy, rd_en;
    logic              own_found_now, src_found_now, res_valid, res_ready;
    logic [AW-1:0]     own_pos_now, src_pos_now, rd_addr;
    logic [CW-1:0]     count_now;
    trmnh_result_t     res;

    assign entry_node  = s_tdata[NODE_W-1:0];
    assign source_node = s_tdata[2*NODE_W-1:NODE_W];
    assign s_tready    = !busy;
    assign accept      = s_tvalid && s_tready;
    assign res_ready   = !m_tvalid_reg || m_tready;

    // list entries past the memory depth are dropped
    always_comb begin
        wr_ok         = count_reg < CW'(MAX_MEMBERS);
        hit_own       = wr_ok && !own_found_reg && (entry_node == own_node_reg);
        hit_src       = wr_ok && !src_found_reg && (entry_node == source_node);
        own_found_now = own_found_reg || hit_own;
        src_found_now = src_found_reg || hit_src;
        own_pos_now   = hit_own ? count_reg[AW-1:0] : own_pos_reg;
        src_pos_now   = hit_src ? count_reg[AW-1:0] : src_pos_reg;
        count_now     = wr_ok ? count_reg + CW'(1) : count_reg;
    end

    always_comb begin
        own_node_next  = cfg_wr_en ? cfg_wr_data : own_node_reg;
        count_next     = count_reg;
        own_found_next = own_found_reg;
        own_pos_next   = own_pos_reg;
        src_found_next = src_found_reg;
        src_pos_next   = src_pos_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next     = '0;
                own_found_next = 1'b0;
                src_found_next = 1'b0;
            end else begin
                count_next     = count_now;
                own_found_next = own_found_now;
                own_pos_next   = own_pos_now;
                src_found_next = src_found_now;
                src_pos_next   = src_pos_now;
            end
        end
        m_res_next    = res_valid ? res : m_res_reg;
        m_tvalid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_reg  <= '0;
            count_reg     <= '0;
            own_found_reg <= 1'b0;
            src_found_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            own_node_reg  <= own_node_next;
            count_reg     <= count_next;
            own_found_reg <= own_found_next;
            src_found_reg <= src_found_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        own_pos_reg <= own_pos_next;
        src_pos_reg <= src_pos_next;
        m_res_reg   <= m_res_next;
    end

    trmnh_member_mem #(
        .DEPTH (MAX_MEMBERS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (accept && wr_ok),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (entry_node),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    trmnh_seq #(
        .AW (AW),
        .CW (CW)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (accept && s_tlast),
        .start_role      (s_tuser),
        .start_count     (count_now),
        .start_own_found (own_found_now),
        .start_own_pos   (own_pos_now),
        .start_src_found (src_found_now),
        .start_src_pos   (src_pos_now),
        .own_node        (own_node_reg),
        .busy            (busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .res_valid       (res_valid),
        .res             (res),
        .res_ready       (res_ready)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg.dest;
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

    `TRMNH_ASSERT_NEXT(a_busy_after_last, aclk, aresetn, accept && s_tlast, !s_tready)
    `TRMNH_ASSERT_NOW(a_count_bound, aclk, aresetn, count_reg <= CW'(MAX_MEMBERS))
    `TRMNH_ASSERT_NOW(a_no_overwrite, aclk, aresetn, !res_valid || res_ready)
    `TRMNH_ASSERT_NOW(a_no_read_on_accept, aclk, aresetn, !(accept && rd_en))

endmodule

### dv/tb.sv
// testbench for two_ring_multicast_next_hop_core: directed table, then random member lists
// depends on trmnh_pkg and the core; results are checked in order against a local next-hop model
module tb;
    import trmnh_pkg::*;

    localparam int LIST_DEPTH = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0]   entry;
        logic [15:0]   src;
        logic          last;
        logic          role;
        logic          typed;
        trmnh_status_t status;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // next-hop model state
    logic [15:0]   members [LIST_DEPTH];
    int unsigned   n_members = 0;
    int unsigned   own_pos = 0;
    logic          own_seen = 1'b0;
    int unsigned   src_pos = 0;
    logic          src_seen = 1'b0;
    logic [15:0]   my_node = '0;
    trmnh_result_t new_hops [3];
    int            n_new;

    trmnh_result_t hop_queue [$];
    trmnh_result_t got;
    int            errors = 0;
    int            n_items = 0;
    int            n_lists = 0;
    int            n_checked = 0;
    int            n_settings = 0;
    int            cycles = 0;
    logic          quiet = 1'b0;

    stim_row_t directed_rows [25] = '{
        '{16'h0005, 16'h0000, 1'b1, 1'b0, 1'b1, STAT_NONE},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0005, 16'h0000, 1'b1, 1'b0, 1'b0, STAT_OK},
        '{16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0005, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0002, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0003, 16'h0000, 1'b1, 1'b0, 1'b0, STAT_OK},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0007, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0008, 16'h0000, 1'b1, 1'b0, 1'b0, STAT_OK},
        '{16'h0005, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0005, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0009, 16'h0000, 1'b0, 1'b0, 1'b0, STAT_OK},
        '{16'h0009, 16'h0000, 1'b1, 1'b0, 1'b1, STAT_ERR},
        '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, STAT_NONE},
        '{16'h0001, 16'h0001, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0002, 16'h0001, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0003, 16'h0001, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0004, 16'h0001, 1'b1, 1'b1, 1'b1, STAT_ERR},
        '{16'h0007, 16'hFFFF, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0005, 16'hFFFF, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0008, 16'hFFFF, 1'b0, 1'b1, 1'b0, STAT_OK},
        '{16'h0009, 16'hFFFF, 1'b1, 1'b1, 1'b1, STAT_NONE}
    };

    two_ring_multicast_next_hop_core #(
        .MAX_MEMBERS(LIST_DEPTH)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned ring_next(int unsigned pos, int unsigned half,
                                              int unsigned n);
        int unsigned nx;
        nx = pos + 1;
        if (pos < half) begin
            if (nx >= half) nx = 0;
        end else begin
            if (nx >= n) nx = half;
        end
        return nx;
    endfunction

    task automatic add_hop(input logic [15:0] dest, input trmnh_status_t status,
                           input logic last);
        new_hops[n_new].dest = dest;
        new_hops[n_new].status = status;
        new_hops[n_new].last = last;
        n_new++;
    endtask

    // stores one entry and, on the last one, works out the forwarding results
    task automatic predict_hops(input logic [15:0] entry, input logic [15:0] src,
                                input logic last, input logic role);
        int unsigned half;
        int unsigned nx;
        int unsigned mid;
        int unsigned start;
        n_new = 0;
        if (n_members < LIST_DEPTH) begin
            members[n_members] = entry;
            if (!own_seen && entry == my_node) begin
                own_seen = 1'b1;
                own_pos = n_members;
            end
            if (!src_seen && entry == src) begin
                src_seen = 1'b1;
                src_pos = n_members;
            end
            n_members++;
        end
        if (!last) return;
        half = n_members / 2;
        if (!role) begin
            if (n_members < SMALL_LIST) begin
                for (int i = 0; i < n_members; i++) begin
                    if (members[i] != my_node) add_hop(members[i], STAT_OK, 1'b0);
                end
                if (n_new == 0) add_hop('0, STAT_NONE, 1'b1);
                else new_hops[n_new-1].last = 1'b1;
            end else begin
                if (own_seen) begin
                    nx = ring_next(own_pos, half, n_members);
                    if (own_pos < half) begin
                        mid = own_pos + half;
                    end else begin
                        mid = own_pos - half;
                        if (mid >= half) mid = 0;
                    end
                end else begin
                    nx = 0;
                    mid = half;
                end
                if (members[nx] == my_node) begin
                    add_hop('0, STAT_ERR, 1'b1);
                end else begin
                    add_hop(members[nx], STAT_OK, 1'b0);
                    add_hop(members[mid], STAT_OK, 1'b1);
                end
            end
        end else if (n_members < SMALL_LIST) begin
            add_hop('0, STAT_NONE, 1'b1);
        end else if (!own_seen) begin
            add_hop('0, STAT_ERR, 1'b1);
        end else begin
            start = src_seen ? src_pos : 0;
            if ((start < half) != (own_pos < half)) begin
                if (start < half) begin
                    start = start + half;
                end else begin
                    start = start - half;
                    if (start >= half) start = 0;
                end
            end
            nx = ring_next(own_pos, half, n_members);
            if (nx == start) add_hop('0, STAT_NONE, 1'b1);
            else add_hop(members[nx], STAT_OK, 1'b1);
        end
        n_members = 0;
        own_pos = 0;
        own_seen = 1'b0;
        src_pos = 0;
        src_seen = 1'b0;
    endtask

    task automatic send_entry(input logic [15:0] entry, input logic [15:0] src,
                              input logic last, input logic role,
                              input logic typed, input trmnh_status_t typed_status);
        trmnh_result_t fixed_hop;
        while (!quiet && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {src, entry};
        s_tlast <= last;
        s_tuser <= role;
        do @(posedge aclk); while (!s_tready);
        predict_hops(entry, src, last, role);
        n_items++;
        if (last) n_lists++;
        if (typed) begin
            fixed_hop.dest = '0;
            fixed_hop.status = typed_status;
            fixed_hop.last = 1'b1;
            hop_queue.push_back(fixed_hop);
        end else begin
            for (int i = 0; i < n_new; i++) hop_queue.push_back(new_hops[i]);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hop_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_own_node(input logic [15:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        my_node = value;
        n_settings++;
    endtask

    // mostly ids drawn from a small pool holding our own id, sometimes pure noise
    task automatic send_random_list(input int len, input logic noisy);
        logic [15:0] pool [4];
        logic [15:0] src;
        logic [15:0] entry;
        logic        role;
        pool[0] = my_node;
        for (int i = 1; i < 4; i++) pool[i] = 16'($urandom);
        role = 1'($urandom_range(1));
        src = ($urandom_range(3) == 0) ? 16'($urandom) : pool[$urandom_range(3)];
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                entry = 16'($urandom);
                src = 16'($urandom);
                role = 1'($urandom_range(1));
            end else begin
                entry = ($urandom_range(4) == 0) ? 16'($urandom) : pool[$urandom_range(3)];
            end
            send_entry(entry, src, i == len - 1, role, 1'b0, STAT_OK);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = n_items + count;
        while (n_items < target)
            send_random_list($urandom_range(1, 10), $urandom_range(4) == 0);
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hop_queue.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: dest=%h status=%0d last=%b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                got = hop_queue.pop_front();
                n_checked++;
                if (m_tdata !== got.dest || m_tuser !== got.status || m_tlast !== got.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"result mismatch: expected dest=%h status=%0d last=%b, ",
                                  "got dest=%h status=%0d last=%b"},
                                 got.dest, got.status, got.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     hop_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_own_node(16'h0005);
        foreach (directed_rows[i])
            send_entry(directed_rows[i].entry, directed_rows[i].src, directed_rows[i].last,
                       directed_rows[i].role, directed_rows[i].typed, directed_rows[i].status);

        set_own_node(16'hFFFF);
        run_random(50);

        set_own_node(16'h0000);
        quiet = 1'b1;
        run_random(50);
        quiet = 1'b0;

        set_own_node(16'($urandom));
        run_random(45);

        drain();
        $display("covered %0d items in %0d lists under %0d own-node settings", n_items, n_lists,
                 n_settings);
        $display("%0d results compared, %0d failures", n_checked, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
